// ===== hdl/edsu_pkg.sv =====
// ----------------------------------------------------------------------------
// Elevator dispatch scorer package
// Shared constants, codes, request and result types and the car score function.
// ----------------------------------------------------------------------------
package edsu_pkg;

  localparam int MAX_CARS   = 8;
  localparam int FLOOR_BITS = 6;
  localparam int CAR_AW     = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
  localparam int CNT_W      = $clog2(MAX_CARS + 1);
  localparam int SCORE_W    = 8;
  localparam int SCORE_CAP  = 254;
  localparam int COUNT_W    = 8;

  localparam logic [SCORE_W-1:0]    SCORE_BROKEN = SCORE_W'(255);
  localparam logic [FLOOR_BITS-1:0] FLOOR_RESET  = FLOOR_BITS'(1);
  localparam logic [COUNT_W-1:0]    COUNT_MAX    = COUNT_W'(255);

  typedef enum logic [2:0] {
    ACT_STATUS,
    ACT_HALL,
    ACT_BROKEN,
    ACT_JAM,
    ACT_TICK
  } action_t;

  typedef enum logic [1:0] {
    MOT_IDLE,
    MOT_UP,
    MOT_DOWN,
    MOT_BROKEN
  } motion_t;

  typedef enum logic [1:0] {
    KIND_DISPATCH,
    KIND_BROKEN,
    KIND_JAM,
    KIND_ALL_IDLE
  } kind_t;

  typedef enum logic {
    CFG_CAR_COUNT,
    CFG_IDLE_LIMIT
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]            action;
    logic [2:0]            car_id;
    logic [FLOOR_BITS-1:0] floor;
    logic [1:0]            motion;
    logic                  up_button;
    logic [FLOOR_BITS-1:0] dest_floor;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [2:0]            target_car;
    logic [1:0]            command_motion;
    logic [FLOOR_BITS-1:0] target_floor;
    logic [FLOOR_BITS-1:0] target_dest;
    logic                  door_jam;
    logic [SCORE_W-1:0]    best_score;
  } out_item_t;

  typedef struct packed {
    logic                  we_floor;
    logic                  we_motion;
    logic [CAR_AW-1:0]     waddr;
    logic [FLOOR_BITS-1:0] wfloor;
    logic [1:0]            wmotion;
    logic                  re;
    logic [CAR_AW-1:0]     raddr;
  } tbl_req_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  function automatic logic [SCORE_W-1:0] car_score(
    input logic [FLOOR_BITS-1:0] cf,
    input logic [1:0]            mo,
    input logic [FLOOR_BITS-1:0] hall,
    input logic                  up
  );
    logic [FLOOR_BITS-1:0] d;
    logic [FLOOR_BITS+1:0] s;
    logic [SCORE_W-1:0]    res;
    d = (cf > hall) ? (cf - hall) : (hall - cf);
    if (mo == MOT_IDLE) begin
      s = {1'b0, d, 1'b0};
    end else if ((mo == MOT_UP && hall > cf && up) ||
                 (mo == MOT_DOWN && hall < cf && !up)) begin
      s = {2'b00, d};
    end else begin
      s = {d, 2'b00};
    end
    if (mo == MOT_BROKEN) begin
      res = SCORE_BROKEN;
    end else if (s > SCORE_CAP) begin
      res = SCORE_W'(SCORE_CAP);
    end else begin
      res = SCORE_W'(s);
    end
    return res;
  endfunction

endpackage

// ===== hdl/edsu_car_table.sv =====
// ----------------------------------------------------------------------------
// Car table
// Floor and motion memories with a registered read; unwritten
// entries read as floor one and idle.
// ----------------------------------------------------------------------------
module edsu_car_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  edsu_pkg::tbl_req_t              req,
  output logic [edsu_pkg::FLOOR_BITS-1:0] rd_floor,
  output logic [1:0]                      rd_motion
);

  logic [edsu_pkg::FLOOR_BITS-1:0] floor_mem_r  [edsu_pkg::MAX_CARS];
  logic [1:0]                      motion_mem_r [edsu_pkg::MAX_CARS];
  logic [edsu_pkg::MAX_CARS-1:0]   fvalid_r;
  logic [edsu_pkg::MAX_CARS-1:0]   mvalid_r;
  logic [edsu_pkg::FLOOR_BITS-1:0] rd_floor_r;
  logic [1:0]                      rd_motion_r;
  logic                            rd_fvalid_r;
  logic                            rd_mvalid_r;

  always_ff @(posedge clk) begin
    if (req.we_floor) begin
      floor_mem_r[req.waddr] <= req.wfloor;
    end
    if (req.we_motion) begin
      motion_mem_r[req.waddr] <= req.wmotion;
    end
    if (req.re) begin
      rd_floor_r  <= floor_mem_r[req.raddr];
      rd_motion_r <= motion_mem_r[req.raddr];
      rd_fvalid_r <= fvalid_r[req.raddr];
      rd_mvalid_r <= mvalid_r[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvalid_r <= '0;
      mvalid_r <= '0;
    end else begin
      if (req.we_floor) begin
        fvalid_r[req.waddr] <= 1'b1;
      end
      if (req.we_motion) begin
        mvalid_r[req.waddr] <= 1'b1;
      end
    end
  end

  assign rd_floor  = rd_fvalid_r ? rd_floor_r : edsu_pkg::FLOOR_RESET;
  assign rd_motion = rd_mvalid_r ? rd_motion_r : edsu_pkg::MOT_IDLE;

endmodule

// ===== hdl/edsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Dispatch controller
// Request decode, table scan with score compare, idle tracking and result
// hand-off to the output register.
// ----------------------------------------------------------------------------
module edsu_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  edsu_pkg::in_item_t              in_data,
  input  logic [3:0]                      car_count,
  input  logic [edsu_pkg::COUNT_W-1:0]    idle_limit,
  output edsu_pkg::tbl_req_t              tbl_req,
  input  logic [edsu_pkg::FLOOR_BITS-1:0] rd_floor,
  input  logic [1:0]                      rd_motion,
  output edsu_pkg::res_t                  res,
  input  logic                            res_take
);

  edsu_pkg::state_t               state_r, state_nxt;
  edsu_pkg::in_item_t             req_r, req_nxt;
  logic [edsu_pkg::CNT_W-1:0]     iss_r, iss_nxt;
  logic                           rdv_r, rdv_nxt;
  logic [edsu_pkg::CAR_AW-1:0]    rdi_r, rdi_nxt;
  logic [edsu_pkg::SCORE_W-1:0]   best_r, best_nxt;
  logic [edsu_pkg::CAR_AW-1:0]    best_idx_r, best_idx_nxt;
  logic                           all_idle_r, all_idle_nxt;
  logic [edsu_pkg::COUNT_W-1:0]   idle_count_r, idle_count_nxt;
  logic                           idle_tracking_r, idle_tracking_nxt;
  logic                           idle_reported_r, idle_reported_nxt;
  edsu_pkg::out_item_t            res_item_r, res_item_nxt;
  logic [edsu_pkg::CNT_W-1:0]     n_cars;
  logic [edsu_pkg::SCORE_W-1:0]   score;
  logic [edsu_pkg::COUNT_W-1:0]   count_inc;

  always_comb begin
    if (car_count == 4'd0) begin
      n_cars = edsu_pkg::CNT_W'(1);
    end else if (car_count > edsu_pkg::MAX_CARS) begin
      n_cars = edsu_pkg::CNT_W'(edsu_pkg::MAX_CARS);
    end else begin
      n_cars = edsu_pkg::CNT_W'(car_count);
    end
  end

  assign score = edsu_pkg::car_score(rd_floor, rd_motion, req_r.floor, req_r.up_button);
  assign count_inc = (idle_count_r == edsu_pkg::COUNT_MAX) ? idle_count_r
                                                           : idle_count_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= edsu_pkg::ST_IDLE;
      rdv_r           <= 1'b0;
      idle_count_r    <= '0;
      idle_tracking_r <= 1'b0;
      idle_reported_r <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      rdv_r           <= rdv_nxt;
      idle_count_r    <= idle_count_nxt;
      idle_tracking_r <= idle_tracking_nxt;
      idle_reported_r <= idle_reported_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    iss_r      <= iss_nxt;
    rdi_r      <= rdi_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    all_idle_r <= all_idle_nxt;
    res_item_r <= res_item_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    req_nxt           = req_r;
    iss_nxt           = iss_r;
    rdv_nxt           = 1'b0;
    rdi_nxt           = rdi_r;
    best_nxt          = best_r;
    best_idx_nxt      = best_idx_r;
    all_idle_nxt      = all_idle_r;
    idle_count_nxt    = idle_count_r;
    idle_tracking_nxt = idle_tracking_r;
    idle_reported_nxt = idle_reported_r;
    res_item_nxt      = res_item_r;
    tbl_req           = '0;
    in_stall          = (state_r != edsu_pkg::ST_IDLE);
    res.valid         = 1'b0;
    res.item          = res_item_r;

    case (state_r)
      edsu_pkg::ST_IDLE: begin
        tbl_req.waddr   = edsu_pkg::CAR_AW'(in_data.car_id);
        tbl_req.wfloor  = in_data.floor;
        tbl_req.wmotion = in_data.motion;
        if (in_valid) begin
          req_nxt = in_data;
          case (edsu_pkg::action_t'(in_data.action))
            edsu_pkg::ACT_STATUS: begin
              if (in_data.car_id < edsu_pkg::MAX_CARS) begin
                tbl_req.we_floor  = 1'b1;
                tbl_req.we_motion = 1'b1;
              end
            end
            edsu_pkg::ACT_HALL, edsu_pkg::ACT_TICK: begin
              iss_nxt      = '0;
              all_idle_nxt = 1'b1;
              best_nxt     = edsu_pkg::SCORE_BROKEN;
              best_idx_nxt = '0;
              state_nxt    = edsu_pkg::ST_SCAN;
            end
            edsu_pkg::ACT_BROKEN: begin
              if (in_data.car_id < edsu_pkg::MAX_CARS) begin
                tbl_req.we_motion = 1'b1;
                tbl_req.wmotion   = edsu_pkg::MOT_BROKEN;
              end
              res_item_nxt                = '0;
              res_item_nxt.kind           = edsu_pkg::KIND_BROKEN;
              res_item_nxt.target_car     = in_data.car_id;
              res_item_nxt.command_motion = edsu_pkg::MOT_BROKEN;
              state_nxt                   = edsu_pkg::ST_EMIT;
            end
            edsu_pkg::ACT_JAM: begin
              res_item_nxt            = '0;
              res_item_nxt.kind       = edsu_pkg::KIND_JAM;
              res_item_nxt.target_car = in_data.car_id;
              res_item_nxt.door_jam   = 1'b1;
              state_nxt               = edsu_pkg::ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end

      edsu_pkg::ST_SCAN: begin
        if (iss_r < n_cars) begin
          tbl_req.re    = 1'b1;
          tbl_req.raddr = iss_r[edsu_pkg::CAR_AW-1:0];
          iss_nxt       = iss_r + 1'b1;
          rdv_nxt       = 1'b1;
          rdi_nxt       = iss_r[edsu_pkg::CAR_AW-1:0];
        end
        if (rdv_r) begin
          if (rdi_r == '0 || score < best_r) begin
            best_nxt     = score;
            best_idx_nxt = rdi_r;
          end
          if (rd_motion != edsu_pkg::MOT_IDLE) begin
            all_idle_nxt = 1'b0;
          end
        end else if (iss_r == n_cars) begin
          if (edsu_pkg::action_t'(req_r.action) == edsu_pkg::ACT_HALL) begin
            res_item_nxt                = '0;
            res_item_nxt.kind           = edsu_pkg::KIND_DISPATCH;
            res_item_nxt.target_car     = 3'(best_idx_r);
            res_item_nxt.command_motion = req_r.up_button ? edsu_pkg::MOT_UP
                                                          : edsu_pkg::MOT_DOWN;
            res_item_nxt.target_floor   = req_r.floor;
            res_item_nxt.target_dest    = req_r.dest_floor;
            res_item_nxt.best_score     = best_r;
            state_nxt                   = edsu_pkg::ST_EMIT;
          end else if (!all_idle_r) begin
            idle_tracking_nxt = 1'b0;
            state_nxt         = edsu_pkg::ST_IDLE;
          end else if (!idle_tracking_r) begin
            idle_tracking_nxt = 1'b1;
            idle_count_nxt    = '0;
            state_nxt         = edsu_pkg::ST_IDLE;
          end else begin
            idle_count_nxt = count_inc;
            if (count_inc >= idle_limit && !idle_reported_r) begin
              idle_reported_nxt = 1'b1;
              res_item_nxt      = '0;
              res_item_nxt.kind = edsu_pkg::KIND_ALL_IDLE;
              state_nxt         = edsu_pkg::ST_EMIT;
            end else begin
              state_nxt = edsu_pkg::ST_IDLE;
            end
          end
        end
      end

      edsu_pkg::ST_EMIT: begin
        res.valid = 1'b1;
        if (res_take) begin
          state_nxt = edsu_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = edsu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/elevator_dispatch_scorer_unit.sv =====
// ----------------------------------------------------------------------------
// Elevator dispatch scorer unit
// Keeps the floor and direction of each car and answers hall calls with the
// nearest suitable car.
// Requests enter on in_valid/in_stall with one in_data item; commands leave on
// out_valid/out_stall through a one-entry output register. Requests are taken
// one at a time. A status update gives no result; a fault or door jam request
// loads its command into the result register on acceptance. A hall call or
// tick scans the car table one entry per cycle through the memory read port.
// Configuration writes on cfg_we/cfg_addr/cfg_wdata are registered; the user
// must make them only while idle, as the block itself does not enforce that.
// Reset is synchronous: every car reads as floor one and idle, idle tracking
// is cleared, car_count returns to 4 and idle_limit to 50. While the
// receiver stalls, the result stays in the output register and the next
// request waiting to give a result is held off.
// ----------------------------------------------------------------------------
module elevator_dispatch_scorer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  edsu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output edsu_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [7:0]          cfg_wdata
);

  logic [3:0]                      car_count_r;
  logic [edsu_pkg::COUNT_W-1:0]    idle_limit_r;
  edsu_pkg::tbl_req_t              tbl_req;
  logic [edsu_pkg::FLOOR_BITS-1:0] rd_floor;
  logic [1:0]                      rd_motion;
  edsu_pkg::res_t                  res;
  logic                            slot_free;
  logic                            out_valid_r;
  edsu_pkg::out_item_t             out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      car_count_r  <= 4'd4;
      idle_limit_r <= edsu_pkg::COUNT_W'(50);
    end else if (cfg_we) begin
      case (edsu_pkg::cfg_index_t'(cfg_addr))
        edsu_pkg::CFG_CAR_COUNT:  car_count_r  <= cfg_wdata[3:0];
        edsu_pkg::CFG_IDLE_LIMIT: idle_limit_r <= cfg_wdata[edsu_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  edsu_car_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (tbl_req),
    .rd_floor  (rd_floor),
    .rd_motion (rd_motion)
  );

  edsu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .car_count  (car_count_r),
    .idle_limit (idle_limit_r),
    .tbl_req    (tbl_req),
    .rd_floor   (rd_floor),
    .rd_motion  (rd_motion),
    .res        (res),
    .res_take   (slot_free)
  );

  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res.valid) begin
      out_data_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && !slot_free |=> res.valid && $stable(res.item))
    else $error("result dropped while the output register was full");

  a_dispatch_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == edsu_pkg::KIND_DISPATCH |->
      out_data.command_motion == edsu_pkg::MOT_UP ||
      out_data.command_motion == edsu_pkg::MOT_DOWN)
    else $error("dispatch without an up or down direction");

  a_nondispatch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != edsu_pkg::KIND_DISPATCH |->
      out_data.best_score == '0 && out_data.target_floor == '0 &&
      out_data.target_dest == '0)
    else $error("dispatch fields set on a non-dispatch command");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> in_stall)
    else $error("request taken while a result is pending");
`endif

endmodule
